### hw/rtl/bef2d_pkg.sv
// Package for big_endian_field_to_double: format codes and stage word types.
// No dependencies.
package bef2d_pkg;

  typedef enum logic [2:0] {
    KIND_INT8  = 3'd0,
    KIND_INT16 = 3'd1,
    KIND_INT32 = 3'd2,
    KIND_INT64 = 3'd3,
    KIND_FP32  = 3'd4,
    KIND_FP64  = 3'd5
  } kind_e;

  // Operand class after decode.
  typedef enum logic [1:0] {
    CLS_INT  = 2'd0,
    CLS_PASS = 2'd1,
    CLS_SUB  = 2'd2
  } cls_e;

  // Word leaving the decode stage.
  typedef struct packed {
    logic        valid;
    cls_e        cls;
    logic        sign;
    logic [63:0] mag;   // integer magnitude, fp32 subnormal mantissa, or pass word
    logic        bad;
  } dec_t;

  // Word leaving the normalize stage.
  typedef struct packed {
    logic        valid;
    cls_e        cls;
    logic        sign;
    logic [63:0] norm;  // leading one at bit 63 (integer / subnormal), or pass word
    logic [5:0]  lz;
    logic        zero;
    logic        bad;
  } nrm_t;

endpackage

### hw/rtl/bef2d_decode.sv
// Decode stage: byte field select, sign split, fp32 special handling.
// Depends on bef2d_pkg.
module bef2d_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [63:0]           raw_bytes_i,
  input  logic [2:0]            kind_i,
  output bef2d_pkg::dec_t       dec_o
);
  import bef2d_pkg::*;

  dec_t        dec_d, dec_q;
  logic [63:0] sx;
  logic [31:0] w;
  logic [7:0]  fe;
  logic [22:0] fm;

  always_comb begin
    dec_d       = '0;
    dec_d.valid = valid_i;
    dec_d.cls   = CLS_PASS;
    sx          = '0;
    w           = raw_bytes_i[63:32];
    fe          = w[30:23];
    fm          = w[22:0];
    unique case (kind_i)
      KIND_INT8:  sx = {{56{raw_bytes_i[63]}}, raw_bytes_i[63:56]};
      KIND_INT16: sx = {{48{raw_bytes_i[63]}}, raw_bytes_i[63:48]};
      KIND_INT32: sx = {{32{raw_bytes_i[63]}}, raw_bytes_i[63:32]};
      default:    sx = raw_bytes_i;
    endcase
    unique case (kind_i)
      KIND_INT8, KIND_INT16, KIND_INT32, KIND_INT64: begin
        dec_d.cls  = CLS_INT;
        dec_d.sign = sx[63];
        dec_d.mag  = sx[63] ? (~sx + 64'd1) : sx;
      end
      KIND_FP32: begin
        dec_d.sign = w[31];
        if (fe == 8'hFF) begin
          dec_d.mag = {w[31], 11'h7FF, (fm != 23'd0), fm[21:0], 29'd0};
          if (fm != 23'd0) dec_d.mag[51] = 1'b1;
          dec_d.mag[51] = dec_d.mag[51] | fm[22];
        end else if (fe == 8'd0) begin
          dec_d.cls = CLS_SUB;
          dec_d.mag = {fm, 41'd0};
        end else begin
          dec_d.mag = {w[31], {3'b000, fe} + 11'd896, fm, 29'd0};
        end
      end
      KIND_FP64: dec_d.mag = raw_bytes_i;
      default:   dec_d.bad = 1'b1;
    endcase
  end

  // Clear only the valid bit on reset; the payload just follows the input.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q.valid <= 1'b0;
    end else begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

endmodule

### hw/rtl/bef2d_norm.sv
// Normalize stage: leading-zero count and left shift of the magnitude.
// Depends on bef2d_pkg.
module bef2d_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bef2d_pkg::dec_t dec_i,
  output bef2d_pkg::nrm_t nrm_o
);
  import bef2d_pkg::*;

  nrm_t        nrm_d, nrm_q;
  logic [63:0] v;
  logic [5:0]  lz;

  // Six-step binary search for the leading one.
  always_comb begin
    v  = dec_i.mag;
    lz = '0;
    if (v[63:32] == 32'd0) begin lz[5] = 1'b1; v = v << 32; end
    if (v[63:48] == 16'd0) begin lz[4] = 1'b1; v = v << 16; end
    if (v[63:56] == 8'd0)  begin lz[3] = 1'b1; v = v << 8;  end
    if (v[63:60] == 4'd0)  begin lz[2] = 1'b1; v = v << 4;  end
    if (v[63:62] == 2'd0)  begin lz[1] = 1'b1; v = v << 2;  end
    if (v[63] == 1'b0)     begin lz[0] = 1'b1; v = v << 1;  end
    nrm_d       = '0;
    nrm_d.valid = dec_i.valid;
    nrm_d.cls   = dec_i.cls;
    nrm_d.sign  = dec_i.sign;
    nrm_d.bad   = dec_i.bad;
    nrm_d.zero  = (dec_i.mag == 64'd0);
    nrm_d.lz    = lz;
    nrm_d.norm  = (dec_i.cls == CLS_PASS) ? dec_i.mag : v;
  end

  // Clear only the valid bit on reset; the payload just follows the input.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q.valid <= 1'b0;
    end else begin
      nrm_q <= nrm_d;
    end
  end

  assign nrm_o = nrm_q;

`ifndef ASSERT_OFF
  // A nonzero magnitude always leaves with its leading one at the top.
  a_norm_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrm_q.valid && nrm_q.cls != CLS_PASS && !nrm_q.zero |-> nrm_q.norm[63])
    else $error("normalized word lacks leading one");
  // Zero flag matches a cleared shifted word.
  a_norm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrm_q.valid && nrm_q.cls == CLS_INT && nrm_q.zero |-> nrm_q.norm == 64'd0)
    else $error("zero flag with nonzero word");
  // Decode valid is registered into this stage's output in the next cycle.
  a_norm_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_i.valid |=> nrm_q.valid)
    else $error("valid lost in normalize stage");
`endif

endmodule

### hw/rtl/bef2d_pack.sv
// Pack stage: rounding, exponent build and result register.
// Depends on bef2d_pkg.
module bef2d_pack (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bef2d_pkg::nrm_t nrm_i,
  output logic            valid_o,
  output logic [63:0]     double_bits_o,
  output logic            bad_format_o
);
  import bef2d_pkg::*;

  logic        valid_q;
  logic [63:0] bits_d, bits_q;
  logic        bad_d, bad_q;
  logic [53:0] keep;
  logic        rnd, lsb, half, sticky;
  logic [10:0] ex;

  always_comb begin
    lsb    = nrm_i.norm[11];
    half   = nrm_i.norm[10];
    sticky = |nrm_i.norm[9:0];
    rnd    = half && (sticky || lsb);
    keep   = {1'b0, nrm_i.norm[63:11]} + {53'd0, rnd};
    ex     = 11'd1086 - {5'd0, nrm_i.lz};
    if (keep[53]) ex = ex + 11'd1;
    bits_d = '0;
    bad_d  = nrm_i.bad;
    if (!nrm_i.bad) begin
      unique case (nrm_i.cls)
        CLS_INT: begin
          if (!nrm_i.zero) begin
            bits_d = {nrm_i.sign, ex, keep[53] ? keep[52:1] : keep[51:0]};
          end
        end
        CLS_SUB: begin
          // Mantissa sat at bit 63 for m[22]; exponent 874 + top bit.
          if (nrm_i.zero) begin
            bits_d = {nrm_i.sign, 63'd0};
          end else begin
            bits_d = {nrm_i.sign, 11'd896 - {5'd0, nrm_i.lz}, nrm_i.norm[62:11]};
          end
        end
        default: bits_d = nrm_i.norm;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= nrm_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    bad_q  <= bad_d;
  end

  assign valid_o       = valid_q;
  assign double_bits_o = bits_q;
  assign bad_format_o  = bad_q;

`ifndef ASSERT_OFF
  // A flagged format always carries an all-zero value.
  a_pack_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bad_q |-> bits_q == 64'd0)
    else $error("bad format with nonzero value");
  // Normalize valid is registered onto the output in the next cycle.
  a_pack_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrm_i.valid |=> valid_q)
    else $error("valid lost in pack stage");
  // Integer results never land on infinity or NaN exponents.
  a_pack_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrm_i.valid && !nrm_i.bad && nrm_i.cls == CLS_INT |=> bits_q[62:52] != 11'h7FF)
    else $error("integer result overflowed exponent");
`endif

endmodule

### hw/rtl/big_endian_field_to_double.sv
// Top level of big_endian_field_to_double: three-stage conversion pipeline.
// Depends on bef2d_pkg, bef2d_decode, bef2d_norm, bef2d_pack.
//
//   channel  | handshake          | word
//   ---------+--------------------+---------------------------------
//   input    | start / busy       | raw_bytes_i[63:0], kind_i[2:0]
//   result   | done_o (strobe)    | double_bits_o[63:0], bad_format_o
//
// Every word passes from start to done_o through decode, normalize
// (leading-zero search and shift), then round and pack. A new word may enter
// every cycle; busy stays low since the receiver cannot stall the strobe.
// Reset clears the stage valid bits only; payload registers are left as is.
module big_endian_field_to_double (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] raw_bytes_i,
  input  logic [2:0]  kind_i,
  output logic        done_o,
  output logic [63:0] double_bits_o,
  output logic        bad_format_o
);
  import bef2d_pkg::*;

  dec_t dec;
  nrm_t nrm;

  // Never hold off a word: the pipe drains one per cycle.
  assign busy = 1'b0;

  bef2d_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start && !busy),
    .raw_bytes_i (raw_bytes_i),
    .kind_i      (kind_i),
    .dec_o       (dec)
  );

  bef2d_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dec_i  (dec),
    .nrm_o  (nrm)
  );

  bef2d_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nrm_i         (nrm),
    .valid_o       (done_o),
    .double_bits_o (double_bits_o),
    .bad_format_o  (bad_format_o)
  );

`ifndef ASSERT_OFF
  // An accepted word appears at the output after the decode, normalize and pack registers.
  a_top_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##3 done_o)
    else $error("word did not arrive after three cycles");
  // No strobe without an accepted word that has passed the decode, normalize and pack registers.
  a_top_nospur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3))
    else $error("spurious result strobe");
  // Passthrough of fp64 is bit exact.
  a_top_fp64: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && kind_i == KIND_FP64 |-> ##3 double_bits_o == $past(raw_bytes_i, 3))
    else $error("fp64 word altered");
`endif

endmodule
